// File: sv/sfc_pkg.sv
// Package with the shared types, constants and the CRC-8 step of the sensor frame checker.
`default_nettype none

package sfc_pkg;

	localparam int BYTE_W  = 8;
	localparam int DBM_W   = 9;
	localparam int KIND_W  = 2;
	localparam int LEVEL_W = 3;
	localparam int KEY_W   = 32;
	localparam int REG_IDX_W = 2;

	localparam logic [KEY_W-1:0]  KEY_RESET    = 32'h6789_ABCD;
	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hB5;
	localparam logic [BYTE_W-1:0] CRC_POLY     = 8'h8C;

	// Strength thresholds in dBm, compared as signed values.
	localparam logic signed [DBM_W-1:0] THR_WEAK   = -9'sd100;
	localparam logic signed [DBM_W-1:0] THR_FAIR   = -9'sd80;
	localparam logic signed [DBM_W-1:0] THR_GOOD   = -9'sd60;
	localparam logic signed [DBM_W-1:0] THR_STRONG = -9'sd50;

	// Configuration register indexes.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_KEY    = 2'd0,
		REG_HEADER = 2'd1
	} reg_idx_t;

	// Reading kinds.
	localparam logic [KIND_W-1:0] KIND_WATER   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_OUTDOOR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_OTHER   = 2'd2;

	typedef struct packed {
		logic                frame_ok;
		logic                header_ok;
		logic                crc_ok;
		logic [KIND_W-1:0]   reading_kind;
		logic [BYTE_W-1:0]   reading_value;
		logic [LEVEL_W-1:0]  signal_level;
	} result_t;

	// One byte of a reflected CRC-8, one bit per step.
	function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: sv/sfc_if.sv
// Channel interfaces of the sensor frame checker: input bytes, results and register writes.
`default_nettype none

interface sfc_in_if;
	logic                                valid;
	logic                                ready;
	logic [sfc_pkg::BYTE_W-1:0]          rx_byte;
	logic                                last_byte;
	logic signed [sfc_pkg::DBM_W-1:0]    signal_dbm;

	modport source (output valid, output rx_byte, output last_byte, output signal_dbm,
		input ready);
	modport sink (input valid, input rx_byte, input last_byte, input signal_dbm,
		output ready);
endinterface

interface sfc_out_if;
	logic                          valid;
	logic                          ready;
	logic                          frame_ok;
	logic                          header_ok;
	logic                          crc_ok;
	logic [sfc_pkg::KIND_W-1:0]    reading_kind;
	logic [sfc_pkg::BYTE_W-1:0]    reading_value;
	logic [sfc_pkg::LEVEL_W-1:0]   signal_level;

	modport source (output valid, output frame_ok, output header_ok, output crc_ok,
		output reading_kind, output reading_value, output signal_level, input ready);
	modport sink (input valid, input frame_ok, input header_ok, input crc_ok,
		input reading_kind, input reading_value, input signal_level, output ready);
endinterface

interface sfc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [sfc_pkg::REG_IDX_W-1:0]     index;
	logic [sfc_pkg::KEY_W-1:0]         data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/sensor_frame_checker_unit.sv
// Sensor frame checker: descrambles frame bytes, checks header and CRC-8, reports the reading.
//
// Usage: received frame bytes arrive one request at a time on in_ch (rx_byte, last_byte and
// the frame's signal_dbm). Bytes 0 to 3 are XOR-descrambled with the key bytes, top byte
// first. On the byte marked last, a frame of at least four bytes yields one request on
// out_ch with the header and CRC checks, the reading kind and value, and a signal level.
// Shorter frames end silently; bytes after the fourth are ignored but a last mark still ends
// the frame. Register writes come on cfg_ch and are always taken in the cycle they appear.
//
// Timing: a byte is captured in the input stage register, where its work is done; the result,
// if any, is then loaded into the output register, which drives out_ch until the receiver
// takes it.
// Throughput: one byte per cycle while no result waits on the receiver (see Stall). The frame
// state update is a single CRC-8 byte step and a few compares, done from the input stage.
// Stall: when the output register still holds a result that the receiver has not taken, a
// further last byte that would make a result waits in the input stage and in_ch.ready drops;
// bytes that make no result keep flowing.
// Reset: arst_n clears the frame state, both valid flags, and loads the key 0x6789ABCD and
// the header value 0xB5.
`default_nettype none

module sensor_frame_checker_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sfc_in_if.sink      in_ch,
	sfc_out_if.source   out_ch,
	sfc_cfg_if.sink     cfg_ch
);
	import sfc_pkg::*;

	// Frame positions of the four checked bytes and the saturated count.
	localparam logic [2:0] POS_HEADER = 3'd0;
	localparam logic [2:0] POS_KIND   = 3'd1;
	localparam logic [2:0] POS_VALUE  = 3'd2;
	localparam logic [2:0] POS_CHECK  = 3'd3;
	localparam logic [2:0] POS_DONE   = 3'd4;

	// Configuration registers.
	logic [KEY_W-1:0]  key_q;
	logic [BYTE_W-1:0] header_q;

	// Input stage.
	logic                     valid_s1;
	logic [BYTE_W-1:0]        rx_byte_s1;
	logic                     last_s1;
	logic signed [DBM_W-1:0]  dbm_s1;

	// Frame state.
	logic [2:0]        pos_q;
	logic [BYTE_W-1:0] crc_q;
	logic              hdr_match_q;
	logic [BYTE_W-1:0] kind_q;
	logic [BYTE_W-1:0] value_q;
	logic [BYTE_W-1:0] check_q;

	// Output register.
	logic    out_valid_q;
	result_t out_q;

	logic [BYTE_W-1:0] key_byte;
	logic [BYTE_W-1:0] dbyte;
	logic [2:0]        pos_next;
	logic [BYTE_W-1:0] crc_next;
	logic              hdr_next;
	logic [BYTE_W-1:0] kind_next;
	logic [BYTE_W-1:0] value_next;
	logic [BYTE_W-1:0] check_next;
	logic              makes_result;
	logic              advance;
	logic              in_fire;
	result_t           res;

	// Register writes are always accepted; indexes beyond the list are dropped.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= KEY_RESET;
			header_q <= HEADER_RESET;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_KEY:    key_q    <= cfg_ch.data;
				REG_HEADER: header_q <= cfg_ch.data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// The key byte for the current position, top byte first.
	always_comb begin
		case (pos_q)
			POS_HEADER: key_byte = key_q[31:24];
			POS_KIND:   key_byte = key_q[23:16];
			POS_VALUE:  key_byte = key_q[15:8];
			POS_CHECK:  key_byte = key_q[7:0];
			default:    key_byte = '0;
		endcase
	end

	assign dbyte = rx_byte_s1 ^ key_byte;

	// Next frame state for the byte in the input stage.
	always_comb begin
		pos_next   = pos_q;
		crc_next   = crc_q;
		hdr_next   = hdr_match_q;
		kind_next  = kind_q;
		value_next = value_q;
		check_next = check_q;
		case (pos_q)
			POS_HEADER: begin
				hdr_next = (dbyte == header_q);
				crc_next = crc8_byte(crc_q, dbyte);
				pos_next = POS_KIND;
			end
			POS_KIND: begin
				kind_next = dbyte;
				crc_next  = crc8_byte(crc_q, dbyte);
				pos_next  = POS_VALUE;
			end
			POS_VALUE: begin
				value_next = dbyte;
				crc_next   = crc8_byte(crc_q, dbyte);
				pos_next   = POS_CHECK;
			end
			POS_CHECK: begin
				check_next = dbyte;
				pos_next   = POS_DONE;
			end
			default: ;
		endcase
	end

	// A result comes from a last byte once four bytes have been seen.
	assign makes_result = last_s1 && (pos_next == POS_DONE);

	always_comb begin
		res.header_ok = hdr_next;
		res.crc_ok    = (check_next == crc_next);
		res.frame_ok  = hdr_next && (check_next == crc_next);
		if (kind_next == 8'd0) begin
			res.reading_kind = KIND_WATER;
		end else if (kind_next == 8'd1) begin
			res.reading_kind = KIND_OUTDOOR;
		end else begin
			res.reading_kind = KIND_OTHER;
		end
		res.reading_value = value_next;
		res.signal_level  = LEVEL_W'(dbm_s1 > THR_WEAK) + LEVEL_W'(dbm_s1 > THR_FAIR)
			+ LEVEL_W'(dbm_s1 > THR_GOOD) + LEVEL_W'(dbm_s1 > THR_STRONG);
	end

	// The input stage moves on unless its result would overwrite an untaken one.
	assign advance      = valid_s1 && (!makes_result || !out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign in_fire      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rx_byte_s1 <= in_ch.rx_byte;
			last_s1    <= in_ch.last_byte;
			dbm_s1     <= in_ch.signal_dbm;
		end
	end

	// Frame state; any last byte returns it to the start of a frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_HEADER;
			crc_q       <= '0;
			hdr_match_q <= 1'b0;
			kind_q      <= '0;
			value_q     <= '0;
			check_q     <= '0;
		end else if (advance) begin
			if (last_s1) begin
				pos_q       <= POS_HEADER;
				crc_q       <= '0;
				hdr_match_q <= 1'b0;
				kind_q      <= '0;
				value_q     <= '0;
				check_q     <= '0;
			end else begin
				pos_q       <= pos_next;
				crc_q       <= crc_next;
				hdr_match_q <= hdr_next;
				kind_q      <= kind_next;
				value_q     <= value_next;
				check_q     <= check_next;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && makes_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && makes_result) begin
			out_q <= res;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.frame_ok      = out_q.frame_ok;
	assign out_ch.header_ok     = out_q.header_ok;
	assign out_ch.crc_ok        = out_q.crc_ok;
	assign out_ch.reading_kind  = out_q.reading_kind;
	assign out_ch.reading_value = out_q.reading_value;
	assign out_ch.signal_level  = out_q.signal_level;

endmodule

`default_nettype wire
